// File: rtl/pvh_pkg.sv
//------------------------------------------------------------------------------
// pvh_pkg
// shared constants and command codes for the pixel value histogram
//------------------------------------------------------------------------------
`default_nettype none
package pvh_pkg;
    localparam int MAX_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 32;
    localparam int VAL_W   = 35;
    localparam int WID_W   = 34;
    localparam int POP_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 35;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] MODE_DIG  = 2'd0;
    localparam logic [1:0] MODE_ANA  = 2'd1;
    localparam logic [1:0] MODE_CMB  = 2'd2;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DARK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NBINS  = 3'd5;
endpackage
`default_nettype wire

// File: rtl/pixel_value_histogram.sv
//------------------------------------------------------------------------------
// pixel_value_histogram
// histogram of formed pixel values with running minimum and maximum
//------------------------------------------------------------------------------
// One command beat in on s_*, one result beat out on m_* for each command.
// Add forms the Q.8 pixel value, updates min/max and counts its bin; read
// returns one bin count; clear zeroes the bins and extremes.
// The bin index comes from a restoring divider that retires one quotient bit
// per cycle over 36 bits. An add runs the divider and then, when the sample
// lands in a counted bin, reads, increments and writes back that bin; a read
// goes through the registered memory read port; an unused command goes
// straight to the result; a clear walks the bin memory one entry a cycle.
// Commands are handled one at a time: the next one can be taken in the cycle
// after the result beat is accepted.
// The bin memory is one synchronous RAM: read, increment, write back.
// After reset the block walks the memory clearing it and takes no command
// until done; config writes are taken at any time.
// A finished result sits in the output register; while the receiver stalls
// the block takes no further command.
//------------------------------------------------------------------------------
`default_nettype none
module pixel_value_histogram #(
    parameter int MAX_BINS   = pvh_pkg::MAX_BINS_DEF,
    parameter int COUNT_BITS = pvh_pkg::COUNT_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [pvh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [pvh_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [1:0]                       s_cmd,
    input  wire  [15:0]                      s_digital_count,
    input  wire  signed [15:0]               s_analog_value,
    input  wire  signed [15:0]               s_dark_value,
    input  wire  [7:0]                       s_read_bin,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [pvh_pkg::POP_W-1:0]        m_bin_population,
    output logic signed [pvh_pkg::VAL_W-1:0] m_pixel_value,
    output logic                             m_in_range,
    output logic signed [pvh_pkg::VAL_W-1:0] m_lowest_value,
    output logic signed [pvh_pkg::VAL_W-1:0] m_highest_value,
    output logic                             m_any_samples
);
    import pvh_pkg::*;

    localparam int AW  = $clog2(MAX_BINS);
    localparam int CW  = AW + 1;
    localparam int DW  = VAL_W + 1;   // dividend bits
    localparam int QCW = $clog2(DW + 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [7:0] {
        ST_INIT  = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_RD    = 8'b0000_1000,
        ST_WR    = 8'b0001_0000,
        ST_RDATA = 8'b0010_0000,
        ST_CLR   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [1:0]              mode_reg;
    logic                    dark_reg;
    logic [15:0]             scale_reg;
    logic signed [VAL_W-1:0] origin_reg;
    logic [WID_W-1:0]        width_reg;
    logic [8:0]              nbins_reg;

    // extremes
    logic signed [VAL_W-1:0] min_reg, max_reg;
    logic                    seen_reg;

    // work registers
    logic signed [VAL_W-1:0] val_reg;
    logic [DW-1:0]           rem_reg, dvd_reg;
    logic [DW-1:0]           quo_reg;
    logic [QCW-1:0]          step_reg;
    logic                    neg_reg;
    logic [AW-1:0]           addr_reg;
    logic [CW-1:0]           clr_reg;
    logic                    hit_reg;
    logic                    rd_ok_reg;

    logic [COUNT_BITS-1:0]   mem [MAX_BINS];
    logic [COUNT_BITS-1:0]   rdata_reg;
    logic                    we;
    logic [AW-1:0]           waddr;
    logic [COUNT_BITS-1:0]   wdata;

    logic [POP_W-1:0]        pop_reg;
    logic signed [VAL_W-1:0] oval_reg;
    logic                    ohit_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_DIG;
            dark_reg   <= 1'b0;
            scale_reg  <= 16'd256;
            origin_reg <= '0;
            width_reg  <= WID_W'(256);
            nbins_reg  <= 9'd256;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_DARK:   dark_reg   <= cfg_data[0];
                REG_SCALE:  scale_reg  <= cfg_data[15:0];
                REG_ORIGIN: origin_reg <= cfg_data[VAL_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_data[WID_W-1:0];
                REG_NBINS:  nbins_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // value forming
    logic signed [VAL_W-1:0] ana_q, drk_q, prod, formed, sum;
    always_comb begin
        ana_q = VAL_W'(s_analog_value) <<< 8;
        drk_q = VAL_W'(s_dark_value) <<< 8;
        prod  = $signed({3'b0, 32'(s_digital_count) * 32'(scale_reg)});
        sum   = (mode_reg == MODE_CMB) ? prod + ana_q : ana_q;
        if (dark_reg) sum = sum - drk_q;
        if (mode_reg == MODE_ANA || mode_reg == MODE_CMB) formed = sum;
        else formed = $signed({11'b0, s_digital_count, 8'b0});
    end

    logic signed [DW-1:0] diff;
    logic [DW-1:0]        wdiv, trial;
    logic [DW-1:0]        rem_sh;
    assign diff   = DW'(formed) - DW'(origin_reg);
    assign wdiv   = (width_reg == '0) ? DW'(1) : DW'(width_reg);
    assign rem_sh = {rem_reg[DW-2:0], dvd_reg[DW-1]};
    assign trial  = rem_sh - wdiv;

    logic [CW-1:0] nb_lim;
    assign nb_lim = (32'(nbins_reg) > 32'(MAX_BINS)) ? CW'(MAX_BINS) : CW'(nbins_reg);

    logic in_bins;
    assign in_bins = (quo_reg < DW'(nb_lim));

    always_comb begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = addr_reg;
        wdata = (rdata_reg == CNT_MAX) ? rdata_reg : rdata_reg + 1'b1;
        unique case (state_reg)
            ST_INIT: begin
                we = 1'b1; waddr = clr_reg[AW-1:0]; wdata = '0;
                if (clr_reg == CW'(MAX_BINS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: if (s_valid) begin
                unique case (s_cmd)
                    CMD_ADD:   state_next = ST_DIV;
                    CMD_READ:  state_next = ST_RD;
                    CMD_CLEAR: state_next = ST_CLR;
                    default:   state_next = ST_OUT;
                endcase
            end
            ST_DIV: if (step_reg == '0) state_next = (!neg_reg && in_bins) ? ST_RD : ST_OUT;
            ST_RD:  state_next = hit_reg ? ST_WR : ST_RDATA;
            ST_WR: begin
                we = 1'b1;
                state_next = ST_OUT;
            end
            ST_RDATA: state_next = ST_OUT;
            ST_CLR: begin
                we = 1'b1; waddr = clr_reg[AW-1:0]; wdata = '0;
                if (clr_reg == CW'(MAX_BINS - 1)) state_next = ST_OUT;
            end
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // bin memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            clr_reg   <= '0;
            min_reg   <= '0;
            max_reg   <= '0;
            seen_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_INIT, ST_CLR: clr_reg <= clr_reg + 1'b1;
                ST_IDLE: begin
                    clr_reg <= '0;
                    hit_reg <= 1'b0;
                    if (s_valid && s_cmd == CMD_ADD) begin
                        seen_reg <= 1'b1;
                        if (!seen_reg || formed < min_reg) min_reg <= formed;
                        if (!seen_reg || formed > max_reg) max_reg <= formed;
                    end
                    if (s_valid && s_cmd == CMD_CLEAR) begin
                        seen_reg <= 1'b0;
                        min_reg  <= '0;
                        max_reg  <= '0;
                    end
                end
                ST_DIV: if (step_reg == '0) hit_reg <= !neg_reg && in_bins;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                val_reg   <= formed;
                rem_reg   <= '0;
                dvd_reg   <= diff;
                neg_reg   <= diff[DW-1];
                quo_reg   <= '0;
                step_reg  <= QCW'(DW);
                addr_reg  <= AW'(s_read_bin);
                rd_ok_reg <= (32'(s_read_bin) < 32'(MAX_BINS));
                pop_reg   <= '0;
                oval_reg  <= '0;
                ohit_reg  <= 1'b0;
            end
            ST_DIV: begin
                if (step_reg != '0) begin
                    dvd_reg  <= {dvd_reg[DW-2:0], 1'b0};
                    step_reg <= step_reg - 1'b1;
                    if (rem_sh >= wdiv) begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[DW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DW-2:0], 1'b0};
                    end
                end else begin
                    addr_reg <= quo_reg[AW-1:0];
                    oval_reg <= val_reg;
                    ohit_reg <= !neg_reg && in_bins;
                end
            end
            ST_RDATA: begin
                if (!rd_ok_reg) pop_reg <= '0;
                else if (COUNT_BITS > POP_W && (rdata_reg >> POP_W) != '0)
                    pop_reg <= '1;
                else pop_reg <= POP_W'(rdata_reg);
            end
            default: ;
        endcase
    end

    assign m_valid          = (state_reg == ST_OUT);
    assign m_bin_population = pop_reg;
    assign m_pixel_value    = oval_reg;
    assign m_in_range       = ohit_reg;
    assign m_lowest_value   = min_reg;
    assign m_highest_value  = max_reg;
    assign m_any_samples    = seen_reg;

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("accept while busy");
    a_minmax: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (min_reg <= max_reg)) else $error("min above max");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_pixel_value)))
        else $error("result dropped");
endmodule
`default_nettype wire
